// ===== hw/rtl/graph_topological_sort_defines.svh =====
// Assertion macros shared by the topological sort RTL.
`ifndef GRAPH_TOPOLOGICAL_SORT_DEFINES_SVH
`define GRAPH_TOPOLOGICAL_SORT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define GTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define GTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gts_pkg.sv =====
// Types, constants and helpers for the topological sort block.
package gts_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;

    localparam int VERTEX_W = 10;
    localparam int SLOT_W   = 12;
    localparam int PTR_W    = 13;
    localparam int CNT_W    = 11;

    localparam logic [1:0] CMD_LOAD_ROW = 2'd0;
    localparam logic [1:0] CMD_LOAD_NBR = 2'd1;
    localparam logic [1:0] CMD_RUN      = 2'd2;
    localparam logic [1:0] CMD_POP      = 2'd3;

    localparam logic [1:0] KIND_FINISHED = 2'd0;
    localparam logic [1:0] KIND_VERTEX   = 2'd1;
    localparam logic [1:0] KIND_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [SLOT_W-1:0] index;
        logic [PTR_W-1:0]  value;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [VERTEX_W-1:0] vertex;
    } res_word_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [PTR_W-1:0]    slot;
        logic [PTR_W-1:0]    last;
    } walk_entry_t;

    function automatic logic [PTR_W-1:0] clamp_edge(input logic [PTR_W-1:0] e);
        clamp_edge = (e > PTR_W'(MAX_EDGES)) ? PTR_W'(MAX_EDGES) : e;
    endfunction

endpackage

// ===== hw/rtl/graph_topological_sort.sv =====
// Top level of the depth-first topological sort over a compressed-row graph.
// Loads write the graph memories directly; a pop first reads the order stack memory.
// A run first clears all 1024 visited marks, then walks each vertex and edge,
// with every step waiting on a registered memory read.
// Reset clears the vertex count, order stack pointer and controller; the graph
// memories hold nothing defined until they are loaded.
`include "graph_topological_sort_defines.svh"

module graph_topological_sort (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gts_pkg::CNT_W-1:0]   cfg_word,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  gts_pkg::cmd_word_t          cmd_word,
    output logic                        res_valid,
    input  logic                        res_ready,
    output gts_pkg::res_word_t          res_word
);
    import gts_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_POP      = 4'd1;
    localparam logic [3:0] ST_CLEAR    = 4'd2;
    localparam logic [3:0] ST_ROOT     = 4'd3;
    localparam logic [3:0] ST_ROOT_CHK = 4'd4;
    localparam logic [3:0] ST_ENTER1   = 4'd5;
    localparam logic [3:0] ST_ENTER2   = 4'd6;
    localparam logic [3:0] ST_STEP     = 4'd7;
    localparam logic [3:0] ST_POPW     = 4'd8;
    localparam logic [3:0] ST_NBR      = 4'd9;
    localparam logic [3:0] ST_NCHK     = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    vertex_count_reg;
    logic [CNT_W-1:0]    order_top_reg, order_top_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [CNT_W-1:0]    root_reg, root_next;
    logic [VERTEX_W-1:0] cur_v_reg, cur_v_next;
    logic [PTR_W-1:0]    cur_slot_reg, cur_slot_next;
    logic [PTR_W-1:0]    cur_end_reg, cur_end_next;
    logic [VERTEX_W-1:0] ev_reg, ev_next;
    logic [PTR_W-1:0]    start_reg, start_next;
    logic                res_valid_reg, res_valid_next;
    res_word_t           res_word_reg, res_word_next;

    logic [CNT_W-1:0]    n_eff;
    logic                cmd_fire;
    logic                cmd_is_load;
    walk_entry_t         walk_top;

    logic                rs_we;
    logic [CNT_W-1:0]    rs_waddr, rs_raddr;
    logic [PTR_W-1:0]    rs_wdata, rs_q;
    logic [PTR_W-1:0]    rs_mem [0:MAX_VERTICES];

    logic                nb_we;
    logic [SLOT_W-1:0]   nb_waddr, nb_raddr;
    logic [PTR_W-1:0]    nb_wdata, nb_q;
    logic [PTR_W-1:0]    nb_mem [0:MAX_EDGES-1];

    logic                vis_we, vis_wdata, vis_q;
    logic [VERTEX_W-1:0] vis_waddr, vis_raddr;
    logic                vis_mem [0:MAX_VERTICES-1];

    logic                ord_we;
    logic [VERTEX_W-1:0] ord_waddr, ord_raddr, ord_wdata, ord_q;
    logic [VERTEX_W-1:0] ord_mem [0:MAX_VERTICES-1];

    logic                wk_we;
    logic [VERTEX_W-1:0] wk_waddr, wk_raddr;
    walk_entry_t         wk_wdata, wk_q;
    walk_entry_t         wk_mem [0:MAX_VERTICES-1];

    assign n_eff = (vertex_count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                             : vertex_count_reg;
    assign cmd_is_load = (cmd_word.command == CMD_LOAD_ROW) ||
                         (cmd_word.command == CMD_LOAD_NBR);
    assign cmd_ready = (state_reg == ST_IDLE) && (cmd_is_load || !res_valid_reg || res_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    assign walk_top.vertex = cur_v_reg;
    assign walk_top.slot   = cur_slot_reg;
    assign walk_top.last   = cur_end_reg;

    always_comb
    begin
        state_next     = state_reg;
        order_top_next = order_top_reg;
        depth_next     = depth_reg;
        root_next      = root_reg;
        cur_v_next     = cur_v_reg;
        cur_slot_next  = cur_slot_reg;
        cur_end_next   = cur_end_reg;
        ev_next        = ev_reg;
        start_next     = start_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_word_next  = res_word_reg;

        rs_we     = 1'b0;
        rs_waddr  = cmd_word.index[CNT_W-1:0];
        rs_wdata  = cmd_word.value;
        rs_raddr  = '0;
        nb_we     = 1'b0;
        nb_waddr  = cmd_word.index;
        nb_wdata  = cmd_word.value;
        nb_raddr  = cur_slot_reg[SLOT_W-1:0];
        vis_we    = 1'b0;
        vis_waddr = root_reg[VERTEX_W-1:0];
        vis_wdata = 1'b0;
        vis_raddr = root_reg[VERTEX_W-1:0];
        ord_we    = 1'b0;
        ord_waddr = order_top_reg[VERTEX_W-1:0];
        ord_wdata = cur_v_reg;
        ord_raddr = '0;
        wk_we     = 1'b0;
        wk_waddr  = '0;
        wk_wdata  = walk_top;
        wk_raddr  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd_word.command)
                        CMD_LOAD_ROW:
                        begin
                            rs_we = (cmd_word.index <= SLOT_W'(MAX_VERTICES));
                        end
                        CMD_LOAD_NBR:
                        begin
                            nb_we = 1'b1;
                        end
                        CMD_RUN:
                        begin
                            order_top_next = '0;
                            depth_next     = '0;
                            root_next      = '0;
                            state_next     = ST_CLEAR;
                        end
                        CMD_POP:
                        begin
                            if (order_top_reg != '0)
                            begin
                                ord_raddr      = VERTEX_W'(order_top_reg - CNT_W'(1));
                                order_top_next = order_top_reg - CNT_W'(1);
                                state_next     = ST_POP;
                            end
                            else
                            begin
                                res_valid_next       = 1'b1;
                                res_word_next.kind   = KIND_EMPTY;
                                res_word_next.vertex = '0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                res_valid_next       = 1'b1;
                res_word_next.kind   = KIND_VERTEX;
                res_word_next.vertex = ord_q;
                state_next           = ST_IDLE;
            end
            ST_CLEAR:
            begin
                vis_we = 1'b1;
                if (root_reg == CNT_W'(MAX_VERTICES - 1))
                begin
                    root_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    root_next = root_reg + CNT_W'(1);
                end
            end
            ST_ROOT:
            begin
                if (root_reg >= n_eff)
                begin
                    res_valid_next       = 1'b1;
                    res_word_next.kind   = KIND_FINISHED;
                    res_word_next.vertex = '0;
                    root_next            = '0;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ROOT_CHK;
                end
            end
            ST_ROOT_CHK:
            begin
                if (vis_q)
                begin
                    root_next  = root_reg + CNT_W'(1);
                    state_next = ST_ROOT;
                end
                else
                begin
                    vis_we     = 1'b1;
                    vis_wdata  = 1'b1;
                    rs_raddr   = root_reg;
                    ev_next    = root_reg[VERTEX_W-1:0];
                    state_next = ST_ENTER1;
                end
            end
            ST_ENTER1:
            begin
                rs_raddr   = {1'b0, ev_reg} + CNT_W'(1);
                start_next = clamp_edge(rs_q);
                state_next = ST_ENTER2;
            end
            ST_ENTER2:
            begin
                cur_v_next    = ev_reg;
                cur_slot_next = start_reg;
                cur_end_next  = clamp_edge(rs_q);
                depth_next    = depth_reg + CNT_W'(1);
                state_next    = ST_STEP;
            end
            ST_STEP:
            begin
                if (cur_slot_reg < cur_end_reg)
                begin
                    cur_slot_next = cur_slot_reg + PTR_W'(1);
                    state_next    = ST_NBR;
                end
                else
                begin
                    ord_we         = 1'b1;
                    order_top_next = order_top_reg + CNT_W'(1);
                    depth_next     = depth_reg - CNT_W'(1);
                    if (depth_reg == CNT_W'(1))
                    begin
                        root_next  = root_reg + CNT_W'(1);
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        wk_raddr   = VERTEX_W'(depth_reg - CNT_W'(2));
                        state_next = ST_POPW;
                    end
                end
            end
            ST_POPW:
            begin
                cur_v_next    = wk_q.vertex;
                cur_slot_next = wk_q.slot;
                cur_end_next  = wk_q.last;
                state_next    = ST_STEP;
            end
            ST_NBR:
            begin
                if (nb_q < {2'b00, n_eff})
                begin
                    vis_raddr  = nb_q[VERTEX_W-1:0];
                    ev_next    = nb_q[VERTEX_W-1:0];
                    state_next = ST_NCHK;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_NCHK:
            begin
                if (vis_q)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    wk_we      = 1'b1;
                    wk_waddr   = VERTEX_W'(depth_reg - CNT_W'(1));
                    vis_we     = 1'b1;
                    vis_waddr  = ev_reg;
                    vis_wdata  = 1'b1;
                    rs_raddr   = {1'b0, ev_reg};
                    state_next = ST_ENTER1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            vertex_count_reg <= '0;
            order_top_reg    <= '0;
            depth_reg        <= '0;
            root_reg         <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            order_top_reg <= order_top_next;
            depth_reg     <= depth_next;
            root_reg      <= root_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                vertex_count_reg <= cfg_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_v_reg    <= cur_v_next;
        cur_slot_reg <= cur_slot_next;
        cur_end_reg  <= cur_end_next;
        ev_reg       <= ev_next;
        start_reg    <= start_next;
        res_word_reg <= res_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        rs_q <= rs_mem[rs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        nb_q <= nb_mem[nb_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_q <= vis_mem[vis_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_q <= ord_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wk_we)
        begin
            wk_mem[wk_waddr] <= wk_wdata;
        end
        wk_q <= wk_mem[wk_raddr];
    end

    `GTS_ASSERT_NOW(a_step_has_vertex, state_reg == ST_STEP, depth_reg != '0, "walk step with empty walk stack")
    `GTS_ASSERT_NOW(a_root_walk_empty, state_reg == ST_ROOT, depth_reg == '0, "root scan with walk in progress")
    `GTS_ASSERT_NOW(a_order_bound, 1'b1, order_top_reg <= CNT_W'(MAX_VERTICES), "order stack overflow")
    `GTS_ASSERT_NEXT(a_pop_reads, cmd_fire && (cmd_word.command == CMD_POP) && (order_top_reg != '0), state_reg == ST_POP, "pop did not enter read state")

endmodule

// ===== bench/graph_topological_sort_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the depth-first topological sort block: directed table, then random graphs.
module graph_topological_sort_tb;

    import gts_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 500;
    localparam int REPORT_CAP    = 100;
    localparam res_word_t NO_RESULT = '0;

    typedef struct packed {
        bit                is_cfg;
        logic [CNT_W-1:0]  count;
        cmd_word_t         cmd;
        bit                known;
        res_word_t         outcome;
    } step_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_word  = '0;
    logic             cmd_valid = 1'b0;
    logic             cmd_ready;
    cmd_word_t        cmd_word  = '0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    res_word_t        res_word;

    logic [CNT_W-1:0]    vertex_total = '0;
    logic [PTR_W-1:0]    row_start [0:MAX_VERTICES];
    bit                  row_loaded [0:MAX_VERTICES];
    logic [PTR_W-1:0]    nbr_list [0:MAX_EDGES-1];
    bit                  nbr_loaded [0:MAX_EDGES-1];
    bit                  visited [0:MAX_VERTICES-1];
    logic [VERTEX_W-1:0] order_stack [0:MAX_VERTICES-1];
    int                  order_top = 0;
    int                  path_vertex [0:MAX_VERTICES-1];
    int                  path_slot [0:MAX_VERTICES-1];
    res_word_t           due_results [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int sent_words     = 0;
    int send_idle_pct  = 16;
    int recv_stall_pct = 58;

    graph_topological_sort DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_word  (cfg_word),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int live_vertices();
        return (vertex_total > CNT_W'(MAX_VERTICES)) ? MAX_VERTICES : int'(vertex_total);
    endfunction

    function automatic int edge_limit(int row);
        int e;
        e = int'(row_start[row]);
        return (e > MAX_EDGES) ? MAX_EDGES : e;
    endfunction

    function automatic void walk_graph();
        int n;
        int depth;
        int v;
        int u;
        n = live_vertices();
        for (int i = 0; i < MAX_VERTICES; i++)
            visited[i] = 1'b0;
        order_top = 0;
        depth = 0;
        for (int root = 0; root < n; root++)
        begin
            if (!visited[root])
            begin
                visited[root] = 1'b1;
                path_vertex[0] = root;
                path_slot[0] = edge_limit(root);
                depth = 1;
                while (depth > 0)
                begin
                    v = path_vertex[depth-1];
                    if (path_slot[depth-1] < edge_limit(v + 1))
                    begin
                        u = int'(nbr_list[path_slot[depth-1]]);
                        path_slot[depth-1]++;
                        if (u < n && !visited[u])
                        begin
                            visited[u] = 1'b1;
                            path_vertex[depth] = u;
                            path_slot[depth] = edge_limit(u);
                            depth++;
                        end
                    end
                    else
                    begin
                        depth--;
                        order_stack[order_top] = VERTEX_W'(v);
                        order_top++;
                    end
                end
            end
        end
    endfunction

    task automatic apply_command(cmd_word_t w, bit known, res_word_t fixed);
        res_word_t r;
        bit gives;
        r = '0;
        gives = 1'b0;
        case (w.command)
            CMD_LOAD_ROW:
                if (int'(w.index) <= MAX_VERTICES)
                begin
                    row_start[w.index] = w.value;
                    row_loaded[w.index] = 1'b1;
                end
            CMD_LOAD_NBR:
            begin
                nbr_list[w.index] = w.value;
                nbr_loaded[w.index] = 1'b1;
            end
            CMD_RUN:
            begin
                walk_graph();
                r.kind = KIND_FINISHED;
                gives = 1'b1;
            end
            default:
            begin
                gives = 1'b1;
                if (order_top > 0)
                begin
                    order_top--;
                    r.kind = KIND_VERTEX;
                    r.vertex = order_stack[order_top];
                end
                else
                    r.kind = KIND_EMPTY;
            end
        endcase
        if (gives)
            due_results.push_back(known ? fixed : r);
    endtask

    function automatic cmd_word_t word_of(logic [1:0] c, int idx, int val);
        cmd_word_t w;
        w.command = c;
        w.index = SLOT_W'(idx);
        w.value = PTR_W'(val);
        return w;
    endfunction

    function automatic step_t row_cmd(logic [1:0] c, int idx, int val);
        step_t s;
        s = '0;
        s.cmd = word_of(c, idx, val);
        return s;
    endfunction

    function automatic step_t row_known(logic [1:0] c, logic [1:0] k);
        step_t s;
        s = '0;
        s.cmd = word_of(c, 0, 0);
        s.known = 1'b1;
        s.outcome.kind = k;
        return s;
    endfunction

    function automatic step_t row_cfg(int n);
        step_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.count = CNT_W'(n);
        return s;
    endfunction

    function automatic int pick_neighbor(int n);
        int r;
        r = int'($urandom_range(9));
        if (n > 0 && r < 8)
            return int'($urandom_range(0, n - 1));
        else if (r < 9)
            return n + int'($urandom_range(0, 3));
        return int'($urandom_range(0, 8191));
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("mismatch at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic issue(cmd_word_t w, bit known, res_word_t fixed);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd_word = w;
        do
            @(posedge clk);
        while (!cmd_ready);
        apply_command(w, known, fixed);
        if (!(w.command == CMD_LOAD_ROW && int'(w.index) > MAX_VERTICES))
            sent_words++;
    endtask

    task automatic drain_engine();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] val);
        drain_engine();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_word = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        vertex_total = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_noise(int n);
        case ($urandom_range(3))
            0: issue(word_of(CMD_POP, 0, 0), 1'b0, NO_RESULT);
            1: issue(word_of(CMD_LOAD_ROW, int'($urandom_range(0, 4095)),
                             int'($urandom_range(0, 8191))), 1'b0, NO_RESULT);
            2: issue(word_of(CMD_LOAD_NBR, int'($urandom_range(0, 4095)),
                             int'($urandom_range(0, 8191))), 1'b0, NO_RESULT);
            default: issue(word_of(CMD_LOAD_ROW, int'($urandom_range(0, n)),
                                   int'($urandom_range(0, 8191))), 1'b0, NO_RESULT);
        endcase
    endtask

    // Any row or neighbor entry that the next run would read is loaded first.
    task automatic fill_unloaded();
        int n;
        int lo;
        int hi;
        n = live_vertices();
        if (n > 0)
        begin
            for (int v = 0; v <= n; v++)
                if (!row_loaded[v])
                    issue(word_of(CMD_LOAD_ROW, v, (v == 0) ? 0 : int'(row_start[v-1])),
                          1'b0, NO_RESULT);
            for (int v = 0; v < n; v++)
            begin
                lo = edge_limit(v);
                hi = edge_limit(v + 1);
                for (int s = lo; s < hi; s++)
                    if (!nbr_loaded[s])
                        issue(word_of(CMD_LOAD_NBR, s, int'($urandom_range(0, n - 1))),
                              1'b0, NO_RESULT);
            end
        end
    endtask

    task automatic graph_phase(bit wide);
        cmd_word_t plan [$];
        cmd_word_t w;
        int n;
        int slot;
        int deg;
        int pick;
        int j;
        if (wide)
            write_count(CNT_W'(2047));
        else if (live_vertices() > 60 || $urandom_range(3) != 0)
        begin
            pick = int'($urandom_range(9));
            if (pick < 7)
                write_count(CNT_W'($urandom_range(0, 12)));
            else if (pick < 9)
                write_count(CNT_W'($urandom_range(13, 60)));
            else
                write_count('0);
        end
        n = live_vertices();
        if (wide)
            slot = 0;
        else if ($urandom_range(7) == 0)
            slot = int'($urandom_range(4060, 4095));
        else
            slot = int'($urandom_range(0, 4000));
        for (int v = 0; v <= n; v++)
        begin
            w = word_of(CMD_LOAD_ROW, v, slot);
            if (!wide && $urandom_range(15) == 0)
                w.value = PTR_W'($urandom_range(0, 8191));
            plan.push_back(w);
            if (v < n)
            begin
                deg = wide ? int'($urandom_range(3) == 0) : int'($urandom_range(0, 3));
                repeat (deg)
                    if (slot < MAX_EDGES)
                    begin
                        plan.push_back(word_of(CMD_LOAD_NBR, slot, pick_neighbor(n)));
                        slot++;
                    end
            end
        end
        for (int i = plan.size() - 1; i > 0; i--)
        begin
            j = int'($urandom_range(0, i));
            w = plan[i];
            plan[i] = plan[j];
            plan[j] = w;
        end
        foreach (plan[i])
        begin
            if (!wide && $urandom_range(7) == 0)
                send_noise(n);
            issue(plan[i], 1'b0, NO_RESULT);
        end
        if (!wide && $urandom_range(9) == 0)
        begin
            repeat ($urandom_range(0, 2)) issue(word_of(CMD_POP, 0, 0), 1'b0, NO_RESULT);
            return;
        end
        fill_unloaded();
        issue(word_of(CMD_RUN, int'($urandom_range(0, 4095)), int'($urandom_range(0, 8191))),
              1'b0, NO_RESULT);
        repeat (n + int'($urandom_range(0, 2)))
        begin
            if (!wide && $urandom_range(9) == 0)
                send_noise(n);
            issue(word_of(CMD_POP, int'($urandom_range(0, 4095)), int'($urandom_range(0, 8191))),
                  1'b0, NO_RESULT);
        end
    endtask

    always @(negedge clk)
        res_ready = ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (cfg_valid && cfg_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (res_valid && res_ready)
            begin
                if (due_results.size() == 0)
                    flag_mismatch("unexpected result word, kind", int'(res_word.kind), -1);
                else
                begin
                    want = due_results.pop_front();
                    if (res_word.kind !== want.kind)
                        flag_mismatch("kind", int'(res_word.kind), int'(want.kind));
                    if (res_word.vertex !== want.vertex)
                        flag_mismatch("vertex", int'(res_word.vertex), int'(want.vertex));
                end
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        step_t steps [$];
        int base;
        int mark;
        bit wide_done;
        steps = '{
            row_known(CMD_POP, KIND_EMPTY),
            row_known(CMD_RUN, KIND_FINISHED),
            row_known(CMD_POP, KIND_EMPTY),
            row_cfg(3),
            row_cmd(CMD_LOAD_ROW, 0, 0),
            row_cmd(CMD_LOAD_ROW, 1, 2),
            row_cmd(CMD_LOAD_ROW, 2, 4),
            row_cmd(CMD_LOAD_ROW, 3, 4),
            row_cmd(CMD_LOAD_NBR, 0, 2),
            row_cmd(CMD_LOAD_NBR, 1, 8191),
            row_cmd(CMD_LOAD_NBR, 2, 0),
            row_cmd(CMD_LOAD_NBR, 3, 3),
            row_cmd(CMD_LOAD_ROW, 4095, 8191),
            row_cmd(CMD_LOAD_ROW, 1025, 0),
            row_cmd(CMD_LOAD_ROW, 1024, 4096),
            row_known(CMD_RUN, KIND_FINISHED),
            row_cmd(CMD_POP, 0, 0),
            row_cmd(CMD_POP, 0, 0),
            row_cmd(CMD_LOAD_ROW, 0, 8191),
            row_known(CMD_RUN, KIND_FINISHED),
            row_cmd(CMD_POP, 0, 0),
            row_cmd(CMD_POP, 0, 0),
            row_cmd(CMD_POP, 0, 0),
            row_cmd(CMD_POP, 0, 0)
        };
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
                write_count(steps[i].count);
            else
                issue(steps[i].cmd, steps[i].known, steps[i].outcome);
        end
        base = sent_words;
        wide_done = 1'b0;
        while (sent_words - base < RANDOM_WORDS)
        begin
            if (sent_words - base < RANDOM_WORDS / 3)
            begin
                send_idle_pct = 16;
                recv_stall_pct = 58;
            end
            else if (sent_words - base < 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct = 58;
                recv_stall_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (!wide_done && sent_words - base >= RANDOM_WORDS / 2)
            begin
                mark = sent_words;
                graph_phase(1'b1);
                sent_words = mark;
                wide_done = 1'b1;
            end
            else
                graph_phase(1'b0);
        end
        drain_engine();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== graph_topological_sort.f =====
+incdir+hw/rtl
hw/rtl/gts_pkg.sv
hw/rtl/graph_topological_sort.sv
bench/graph_topological_sort_tb.sv
